### design/disjoint_interval_set_table_assert.svh
// Assertion macros used by the checker file dist_chk.sv.
`ifndef DISJOINT_INTERVAL_SET_TABLE_ASSERT_SVH
`define DISJOINT_INTERVAL_SET_TABLE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define DIST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dist check failed");

// The antecedent implies the consequent in the next cycle.
`define DIST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dist check failed");

`endif

### design/dist_pkg.sv
package dist_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int COORD_BITS_DEF = 48;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FIND   = 3'd2,
    OP_SAME   = 3'd3,
    OP_MEX    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CP_RD,
    S_CP_WR,
    S_WR_NEW,
    S_FIN
  } state_t;

  localparam logic REG_MERGE = 1'b0;

endpackage

### design/dist_mem.sv
module dist_mem #(
  parameter int CAPACITY = dist_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = dist_pkg::COORD_BITS_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic [IW-1:0]         rd_addr,
  output logic [COORD_BITS-1:0] rd_start,
  output logic [COORD_BITS-1:0] rd_end,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  logic [COORD_BITS-1:0] wr_start,
  input  logic [COORD_BITS-1:0] wr_end
);

  logic [2*COORD_BITS-1:0] mem [CAPACITY];
  logic [2*COORD_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_start, wr_end};
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_start = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_end   = rd_data[COORD_BITS-1:0];

endmodule

### design/dist_ctrl.sv
module dist_ctrl #(
  parameter int CAPACITY = dist_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = dist_pkg::COORD_BITS_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  join_touch,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            opcode,
  input  logic [COORD_BITS-1:0] first_coord,
  input  logic [COORD_BITS-1:0] second_coord,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  hit,
  output logic [COORD_BITS-1:0] found_start,
  output logic [COORD_BITS-1:0] found_end,
  output logic [COORD_BITS-1:0] mex_value,
  output logic [IW-1:0]         rd_addr,
  input  logic [COORD_BITS-1:0] rd_start,
  input  logic [COORD_BITS-1:0] rd_end,
  output logic                  wr_en,
  output logic [IW-1:0]         wr_addr,
  output logic [COORD_BITS-1:0] wr_start,
  output logic [COORD_BITS-1:0] wr_end
);

  localparam int XW = COORD_BITS + 1;
  localparam int DW = CW + 1;

  dist_pkg::state_t state, state_next;

  logic [2:0]            op;
  logic [COORD_BITS-1:0] a, b, p;
  logic                  m;
  logic [CW-1:0]         count, new_count;
  logic [CW-1:0]         ra;
  logic                  rv;
  logic [CW-1:0]         ridx;
  logic                  lo_found;
  logic [CW-1:0]         lo, hi;
  logic [COORD_BITS-1:0] lo_start, hi_end;
  logic [1:0]            n;
  logic [COORD_BITS-1:0] ns0, ne0, ns1, ne1;
  logic [CW-1:0]         src, dst, rem;
  logic                  desc;
  logic                  wk;
  logic [1:0]            res_status;
  logic                  res_hit;
  logic [COORD_BITS-1:0] res_fs, res_fe, res_mx;
  logic                  out_free;
  logic                  is_update, empty_range, scan_done;

  logic                  d_mod, d_full, d_skip;
  logic [1:0]            d_n;
  logic [CW-1:0]         d_hi;
  logic [COORD_BITS-1:0] d_ns0, d_ne0, d_ns1, d_ne1, d_tl, d_tr;
  logic [DW-1:0]         d_total;
  logic [CW-1:0]         d_dst0, d_tail;
  logic                  d_hitp;

  assign out_free    = !out_valid || !out_stall;
  assign is_update   = (opcode == dist_pkg::OP_ADD) || (opcode == dist_pkg::OP_REMOVE);
  assign empty_range = first_coord >= second_coord;
  assign scan_done   = (ra == count) && !rv;
  assign p           = (op == dist_pkg::OP_MEX) ? '0 : a;

  always_comb begin
    d_hitp = lo_found && (hi_end > p);
    d_hi   = hi;
    d_ns0  = a;
    d_ne0  = b;
    d_ns1  = b;
    d_ne1  = b;
    d_tl   = a;
    d_tr   = b;
    d_n    = 2'd0;
    d_mod  = 1'b0;
    d_skip = 1'b0;
    if (op == dist_pkg::OP_ADD) begin
      if (hi < lo) begin
        d_hi = lo;
      end
      d_n = 2'd1;
      if (lo < d_hi) begin
        if (lo_start < a) begin
          d_ns0 = lo_start;
        end
        if (hi_end > b) begin
          d_ne0 = hi_end;
        end
      end
    end else begin
      d_skip = hi <= lo;
      d_tl = (lo_start < a) ? lo_start : a;
      d_tr = (hi_end > b) ? hi_end : b;
      if (d_tl < a) begin
        d_ns0 = d_tl;
        d_ne0 = a;
        d_ns1 = b;
        d_ne1 = d_tr;
        d_n = (b < d_tr) ? 2'd2 : 2'd1;
      end else if (b < d_tr) begin
        d_ns0 = b;
        d_ne0 = d_tr;
        d_n = 2'd1;
      end
    end
    d_total = DW'(count) - DW'(d_hi) + DW'(lo) + DW'(d_n);
    d_full  = d_total > DW'(CAPACITY);
    d_tail  = count - d_hi;
    d_dst0  = lo + CW'(d_n);
    d_mod   = !d_skip && !d_full;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dist_pkg::S_IDLE: begin
        if (in_valid) begin
          if (is_update && empty_range) begin
            state_next = dist_pkg::S_FIN;
          end else if (opcode <= dist_pkg::OP_MEX) begin
            state_next = dist_pkg::S_SCAN;
          end else begin
            state_next = dist_pkg::S_FIN;
          end
        end
      end
      dist_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = dist_pkg::S_DECIDE;
        end
      end
      dist_pkg::S_DECIDE: begin
        if ((op == dist_pkg::OP_ADD || op == dist_pkg::OP_REMOVE) && d_mod) begin
          if (d_tail != '0 && d_dst0 != d_hi) begin
            state_next = dist_pkg::S_CP_RD;
          end else begin
            state_next = dist_pkg::S_WR_NEW;
          end
        end else begin
          state_next = dist_pkg::S_FIN;
        end
      end
      dist_pkg::S_CP_RD: state_next = dist_pkg::S_CP_WR;
      dist_pkg::S_CP_WR: begin
        state_next = (rem == CW'(1)) ? dist_pkg::S_WR_NEW : dist_pkg::S_CP_RD;
      end
      dist_pkg::S_WR_NEW: begin
        if ({1'b0, wk} + 2'd1 >= n) begin
          state_next = dist_pkg::S_FIN;
        end
      end
      dist_pkg::S_FIN: begin
        if (out_free) begin
          state_next = dist_pkg::S_IDLE;
        end
      end
      default: state_next = dist_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_addr  = src[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = dst[IW-1:0];
    wr_start = rd_start;
    wr_end   = rd_end;
    unique case (state)
      dist_pkg::S_IDLE: in_stall = 1'b0;
      dist_pkg::S_SCAN: rd_addr = ra[IW-1:0];
      dist_pkg::S_CP_WR: wr_en = 1'b1;
      dist_pkg::S_WR_NEW: begin
        wr_en    = {1'b0, wk} < n;
        wr_addr  = IW'(lo + CW'(wk));
        wr_start = wk ? ns1 : ns0;
        wr_end   = wk ? ne1 : ne0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dist_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rv        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dist_pkg::S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        dist_pkg::S_IDLE: begin
          if (in_valid) begin
            op         <= opcode;
            a          <= first_coord;
            b          <= second_coord;
            m          <= join_touch;
            ra         <= '0;
            rv         <= 1'b0;
            lo_found   <= 1'b0;
            lo         <= count;
            hi         <= '0;
            res_hit    <= 1'b0;
            res_fs     <= '0;
            res_fe     <= '0;
            res_mx     <= '0;
            res_status <= (is_update && empty_range) ? dist_pkg::ST_EMPTY
                                                     : dist_pkg::ST_DONE;
          end
        end
        dist_pkg::S_SCAN: begin
          if (ra != count) begin
            ra   <= ra + CW'(1);
            rv   <= 1'b1;
            ridx <= ra;
          end else begin
            rv <= 1'b0;
          end
          if (rv) begin
            if (op == dist_pkg::OP_ADD || op == dist_pkg::OP_REMOVE) begin
              if (!lo_found && ({1'b0, rd_end} + XW'(op == dist_pkg::OP_ADD && m)
                                > {1'b0, a})) begin
                lo_found <= 1'b1;
                lo       <= ridx;
                lo_start <= rd_start;
              end
              if ({1'b0, rd_start} < {1'b0, b} + XW'(op == dist_pkg::OP_ADD && m)) begin
                hi     <= ridx + CW'(1);
                hi_end <= rd_end;
              end
            end else if (rd_start <= p) begin
              lo_found <= 1'b1;
              lo_start <= rd_start;
              hi_end   <= rd_end;
            end
          end
        end
        dist_pkg::S_DECIDE: begin
          case (op)
            dist_pkg::OP_FIND: begin
              res_hit <= d_hitp;
              res_fs  <= d_hitp ? lo_start : '0;
              res_fe  <= d_hitp ? hi_end : '0;
            end
            dist_pkg::OP_SAME: begin
              res_hit <= d_hitp && (lo_start <= b) && (b < hi_end);
            end
            dist_pkg::OP_MEX: begin
              res_mx <= d_hitp ? hi_end : '0;
            end
            default: begin
              if (!d_skip && d_full) begin
                res_status <= dist_pkg::ST_FULL;
              end
            end
          endcase
          n         <= d_n;
          ns0       <= d_ns0;
          ne0       <= d_ne0;
          ns1       <= d_ns1;
          ne1       <= d_ne1;
          wk        <= 1'b0;
          rem       <= d_tail;
          new_count <= d_total[CW-1:0];
          desc      <= d_dst0 > d_hi;
          if (d_dst0 > d_hi) begin
            src <= count - CW'(1);
            dst <= d_total[CW-1:0] - CW'(1);
          end else begin
            src <= d_hi;
            dst <= d_dst0;
          end
        end
        dist_pkg::S_CP_WR: begin
          rem <= rem - CW'(1);
          if (desc) begin
            src <= src - CW'(1);
            dst <= dst - CW'(1);
          end else begin
            src <= src + CW'(1);
            dst <= dst + CW'(1);
          end
        end
        dist_pkg::S_WR_NEW: begin
          wk <= 1'b1;
          if ({1'b0, wk} + 2'd1 >= n) begin
            count <= new_count;
          end
        end
        dist_pkg::S_FIN: begin
          if (out_free) begin
            status      <= res_status;
            hit         <= res_hit;
            found_start <= res_fs;
            found_end   <= res_fe;
            mex_value   <= res_mx;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/disjoint_interval_set_table.sv
// Sorted table of up to CAPACITY disjoint half-open intervals, held in one
// single-port-read memory of start/end pairs. Every item is handled alone:
// a scan reads the stored entries one per cycle, then add and remove shift
// the tail of the table through the same read port, reading and then
// writing each moved entry, and write at most two new entries. The result
// sits in an output register, so a finished transfer may wait there while
// the next item is taken in.
module disjoint_interval_set_table #(
  parameter int CAPACITY = dist_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = dist_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            opcode,
  input  logic [COORD_BITS-1:0] first_coord,
  input  logic [COORD_BITS-1:0] second_coord,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  hit,
  output logic [COORD_BITS-1:0] found_start,
  output logic [COORD_BITS-1:0] found_end,
  output logic [COORD_BITS-1:0] mex_value
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  join_touch;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic [COORD_BITS-1:0] rd_start, rd_end, wr_start, wr_end;
  logic                  wr_en;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dist_pkg::REG_MERGE) ? {31'b0, join_touch} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      join_touch <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == dist_pkg::REG_MERGE) begin
      join_touch <= pwdata[0];
    end
  end

  dist_mem #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_start(rd_start),
    .rd_end  (rd_end),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_start(wr_start),
    .wr_end  (wr_end)
  );

  dist_ctrl #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .join_touch  (join_touch),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .first_coord (first_coord),
    .second_coord(second_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hit         (hit),
    .found_start (found_start),
    .found_end   (found_end),
    .mex_value   (mex_value),
    .rd_addr     (rd_addr),
    .rd_start    (rd_start),
    .rd_end      (rd_end),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_start    (wr_start),
    .wr_end      (wr_end)
  );

endmodule

### design/dist_chk.sv
`include "disjoint_interval_set_table_assert.svh"

module dist_chk #(
  parameter int COORD_BITS = dist_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            status,
  input logic                  hit,
  input logic [COORD_BITS-1:0] found_start,
  input logic [COORD_BITS-1:0] found_end,
  input logic [COORD_BITS-1:0] mex_value
);

  `DIST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
  `DIST_ASSERT_NOW(a_status_code, out_valid, status != 2'd3)
  `DIST_ASSERT_NOW(a_refused_clean, out_valid && status != 2'd0, !hit && found_start == '0 && found_end == '0 && mex_value == '0)
  `DIST_ASSERT_NOW(a_miss_clean, out_valid && !hit, found_start == '0 && found_end == '0)

endmodule

bind disjoint_interval_set_table dist_chk #(.COORD_BITS(COORD_BITS)) u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .hit        (hit),
  .found_start(found_start),
  .found_end  (found_end),
  .mex_value  (mex_value)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CAP = 64;
  localparam int CB = 48;

  typedef struct packed {
    logic [1:0]    status;
    logic          hit;
    logic [CB-1:0] fstart;
    logic [CB-1:0] fend;
    logic [CB-1:0] mex;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic [CB-1:0] first_coord = '0, second_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic hit;
  logic [CB-1:0] found_start, found_end, mex_value;

  disjoint_interval_set_table u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the interval table.
  longint unsigned iv_lo[CAP];
  longint unsigned iv_hi[CAP];
  int unsigned iv_count = 0;
  logic merge_touching = 1'b1;

  answer_t pending_answers[$];
  int errors = 0;
  int transfers_in = 0, transfers_out = 0, full_refusals = 0, empty_rejects = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_cycles = 0;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic void splice_in(int unsigned lo, int unsigned hi,
                                    longint unsigned ns[2], longint unsigned ne[2],
                                    int unsigned n);
    longint unsigned ts[CAP];
    longint unsigned te[CAP];
    int unsigned k;
    k = 0;
    for (int unsigned i = 0; i < lo; i++) begin
      ts[k] = iv_lo[i]; te[k] = iv_hi[i]; k++;
    end
    for (int unsigned i = 0; i < n; i++) begin
      ts[k] = ns[i]; te[k] = ne[i]; k++;
    end
    for (int unsigned i = hi; i < iv_count; i++) begin
      ts[k] = iv_lo[i]; te[k] = iv_hi[i]; k++;
    end
    for (int unsigned i = 0; i < k; i++) begin
      iv_lo[i] = ts[i]; iv_hi[i] = te[i];
    end
    iv_count = k;
  endfunction

  function automatic int holder_of(longint unsigned p);
    int idx;
    idx = -1;
    for (int unsigned i = 0; i < iv_count && iv_lo[i] <= p; i++) idx = i;
    if (idx >= 0 && iv_hi[idx] > p) return idx;
    return -1;
  endfunction

  function automatic logic [1:0] table_add(longint unsigned l, longint unsigned r);
    longint unsigned m;
    longint unsigned ns[2], ne[2];
    int unsigned lo, hi;
    m = merge_touching;
    lo = 0;
    hi = 0;
    while (lo < iv_count && iv_hi[lo] + m <= l) lo++;
    while (hi < iv_count && iv_lo[hi] < r + m) hi++;
    if (hi < lo) hi = lo;
    if (iv_count - (hi - lo) + 1 > CAP) return dist_pkg::ST_FULL;
    ns[0] = l;
    ne[0] = r;
    if (lo < hi) begin
      if (iv_lo[lo] < ns[0]) ns[0] = iv_lo[lo];
      if (iv_hi[hi-1] > ne[0]) ne[0] = iv_hi[hi-1];
    end
    splice_in(lo, hi, ns, ne, 1);
    return dist_pkg::ST_DONE;
  endfunction

  function automatic logic [1:0] table_remove(longint unsigned l, longint unsigned r);
    longint unsigned ns[2], ne[2];
    longint unsigned tl, tr;
    int unsigned lo, hi, n;
    lo = 0;
    hi = 0;
    n = 0;
    while (lo < iv_count && iv_hi[lo] <= l) lo++;
    while (hi < iv_count && iv_lo[hi] < r) hi++;
    if (hi <= lo) return dist_pkg::ST_DONE;
    tl = iv_lo[lo] < l ? iv_lo[lo] : l;
    tr = iv_hi[hi-1] > r ? iv_hi[hi-1] : r;
    if (tl < l) begin ns[n] = tl; ne[n] = l; n++; end
    if (r < tr) begin ns[n] = r; ne[n] = tr; n++; end
    if (iv_count - (hi - lo) + n > CAP) return dist_pkg::ST_FULL;
    splice_in(lo, hi, ns, ne, n);
    return dist_pkg::ST_DONE;
  endfunction

  function automatic answer_t apply_op(logic [2:0] op, longint unsigned a,
                                       longint unsigned b);
    answer_t ans;
    int idx;
    ans = '0;
    case (op)
      dist_pkg::OP_ADD: begin
        ans.status = (a >= b) ? dist_pkg::ST_EMPTY : table_add(a, b);
      end
      dist_pkg::OP_REMOVE: begin
        ans.status = (a >= b) ? dist_pkg::ST_EMPTY : table_remove(a, b);
      end
      dist_pkg::OP_FIND: begin
        idx = holder_of(a);
        if (idx >= 0) begin
          ans.hit = 1'b1;
          ans.fstart = iv_lo[idx];
          ans.fend = iv_hi[idx];
        end
      end
      dist_pkg::OP_SAME: begin
        idx = holder_of(a);
        if (idx >= 0 && iv_lo[idx] <= b && b < iv_hi[idx]) ans.hit = 1'b1;
      end
      dist_pkg::OP_MEX: begin
        idx = holder_of(0);
        if (idx >= 0) ans.mex = iv_hi[idx];
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic send_item(logic [2:0] op, logic [CB-1:0] a, logic [CB-1:0] b);
    logic taken;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    first_coord = a;
    second_coord = b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    pending_answers.push_back(apply_op(op, a, b));
    transfers_in++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_merge(logic v);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(4 * dist_pkg::REG_MERGE);
    pwdata = {31'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    merge_touching = v;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      transfers_out++;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result transfer at %0t", $realtime);
      end else begin
        want = pending_answers.pop_front();
        if (status == dist_pkg::ST_FULL) full_refusals++;
        if (status == dist_pkg::ST_EMPTY) empty_rejects++;
        if (status !== want.status) report("status", status, want.status);
        if (hit !== want.hit) report("hit", hit, want.hit);
        if (found_start !== want.fstart) report("found_start", found_start, want.fstart);
        if (found_end !== want.fend) report("found_end", found_end, want.fend);
        if (mex_value !== want.mex) report("mex_value", mex_value, want.mex);
      end
    end
  end

  function automatic logic [CB-1:0] wide_coord();
    return CB'({$urandom, $urandom});
  endfunction

  task automatic random_item();
    logic [2:0] op;
    logic [CB-1:0] a, b;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) op = dist_pkg::OP_ADD;
    else if (pick < 65) op = dist_pkg::OP_REMOVE;
    else if (pick < 80) op = dist_pkg::OP_FIND;
    else if (pick < 90) op = dist_pkg::OP_SAME;
    else if (pick < 96) op = dist_pkg::OP_MEX;
    else op = 3'($urandom_range(5, 7));
    if ($urandom_range(9) == 0) begin
      a = wide_coord();
      b = wide_coord();
    end else begin
      a = CB'($urandom_range(2047));
      if (op == dist_pkg::OP_REMOVE && $urandom_range(5) == 0) begin
        b = a + CB'($urandom_range(600));
      end else if (op == dist_pkg::OP_ADD || op == dist_pkg::OP_REMOVE) begin
        b = a + CB'($urandom_range(1, 12));
      end else begin
        b = CB'($urandom_range(2047));
      end
      if ($urandom_range(19) == 0) b = a - CB'($urandom_range(3));
    end
    send_item(op, a, b);
  endtask

  task automatic test_basic_ops();
    logic [CB-1:0] top;
    top = '1;
    send_item(dist_pkg::OP_MEX, 0, 0);
    send_item(dist_pkg::OP_FIND, 5, 0);
    send_item(dist_pkg::OP_ADD, 0, 10);
    send_item(dist_pkg::OP_MEX, 0, 0);
    send_item(dist_pkg::OP_ADD, 10, 20);
    send_item(dist_pkg::OP_FIND, 15, 0);
    send_item(dist_pkg::OP_ADD, 25, 30);
    send_item(dist_pkg::OP_SAME, 5, 15);
    send_item(dist_pkg::OP_SAME, 5, 27);
    send_item(dist_pkg::OP_REMOVE, 3, 5);
    send_item(dist_pkg::OP_FIND, 4, 0);
    send_item(dist_pkg::OP_ADD, 7, 7);
    send_item(dist_pkg::OP_REMOVE, 9, 3);
    send_item(dist_pkg::OP_REMOVE, 100, 200);
    send_item(3'd5, top, top);
    send_item(3'd6, top, 0);
    send_item(3'd7, 0, top);
    send_item(dist_pkg::OP_ADD, top - 1, top);
    send_item(dist_pkg::OP_FIND, top - 1, 0);
    send_item(dist_pkg::OP_FIND, top, 0);
    send_item(dist_pkg::OP_REMOVE, 0, top);
    wait_drained();
  endtask

  task automatic test_touching_kept_apart();
    write_merge(1'b0);
    send_item(dist_pkg::OP_ADD, 0, 8);
    send_item(dist_pkg::OP_ADD, 8, 16);
    send_item(dist_pkg::OP_MEX, 0, 0);
    send_item(dist_pkg::OP_SAME, 2, 9);
    wait_drained();
  endtask

  task automatic test_random(int n, int s_idle, int r_stall, logic merge);
    write_merge(merge);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    repeat (n) random_item();
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 400;
    repeat (30) random_item();
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_merge(1'b1);
    test_basic_ops();
    test_touching_kept_apart();
    test_random(130, 12, 63, 1'b0);
    test_random(130, 63, 12, 1'b1);
    test_backpressure();
    test_random(130, 0, 0, 1'b0);
    repeat (20) @(posedge clk);
    $display("Sent %0d items and checked %0d results over merge settings 0 and 1.",
             transfers_in, transfers_out);
    $display("Saw %0d refusals for a full table and %0d empty-range rejects.",
             full_refusals, empty_rejects);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding.", pending_answers.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
